### rtl/ntc_pkg.sv
// shared constants, types and codes of the thermistor conversion block
`timescale 1ns / 1ps
package ntc_pkg;

   // defaults of the top level parameters
   localparam int ADC_BITS_DEF  = 12;
   localparam int TEMP_FRAC_DEF = 8;

   // field and register widths
   localparam int RES_W      = 24;
   localparam int COEF_W     = 48;
   localparam int TEMP_W     = 20;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // log2 pipeline: normalized mantissa and fraction bits
   localparam int FRAC_W  = 32;
   localparam int NORM_W  = 31;
   localparam int LOG_LAT = FRAC_W + 1;

   // multiply-shift unit
   localparam int OP_W       = 49;
   localparam int MAG_W      = 48;
   localparam int HALF_W     = 24;
   localparam int PROD_W     = 63;
   localparam int PROD_SHIFT = 32;
   localparam int MUL_LAT    = 4;
   localparam logic [PROD_W-2:0] PROD_LIM = 62'h2000_0000_0000_0000;

   localparam int LG_W     = 40;
   localparam int D_W      = 64;
   localparam int LOW_CODE = 10;

   localparam logic signed [OP_W-1:0] LN2_Q32 = 49'sd2977044472;

   localparam logic signed [TEMP_W-1:0] T_MAX = 20'sh7FFFF;
   localparam logic signed [TEMP_W-1:0] T_MIN = 20'sh80000;
   localparam int T_MAX_VAL = 524287;

   // register reset values
   localparam logic [RES_W-1:0]         RES_RESET = 24'd10000;
   localparam logic signed [COEF_W-1:0] A_RESET   = 48'sd284078485801;
   localparam logic signed [COEF_W-1:0] B_RESET   = 48'sd66946161643;
   localparam logic signed [COEF_W-1:0] C_RESET   = 48'sd56835503;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RES,
      CSR_COEFF_A,
      CSR_COEFF_B,
      CSR_COEFF_C
   } csr_index_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_RANGE,
      STAT_SAT
   } status_type;

   typedef struct packed {
      logic vld;
      logic oor;
   } meta_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [STAT_W-1:0]        status;
   } result_type;

endpackage

### rtl/ntc_if.sv
// channel interfaces: converter codes in, temperatures out, register writes
`timescale 1ns / 1ps
interface ntc_req_if #(parameter int CODE_W = ntc_pkg::ADC_BITS_DEF);
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] adc_code;
   modport source (output valid, output adc_code, input ready);
   modport sink (input valid, input adc_code, output ready);
endinterface

interface ntc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [ntc_pkg::TEMP_W-1:0] temperature;
   logic [ntc_pkg::STAT_W-1:0]        status;
   modport source (output valid, output temperature, output status, input ready);
   modport sink (input valid, input temperature, input status, output ready);
endinterface

interface ntc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ntc_pkg::CSR_IDX_W-1:0]    index;
   logic [ntc_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ntc_thermistor_to_celsius.sv
// top level: thermistor divider code to temperature in 1/2^F degree Celsius
`timescale 1ns / 1ps
// One converter code enters per clock while the output buffer has room, and one
// temperature leaves per code, in order. On the way a code passes the log2 pipeline
// (one squaring step per stage), four chained 4-stage multipliers for ln R, ln^2,
// ln^3 and the cubic term, a restoring divider that retires one quotient bit per
// stage (QB + 1 stages, QB = 20 at the default scale), and a two-entry output
// buffer. The pipeline stalls as a whole only when that buffer holds two results.
// Codes below 10 or above full scale minus 10 give -50 C with status 1; results
// clamped to the 20-bit range, or a non-positive denominator, give status 2. A zero
// resistor value counts as one ohm. The user must write coefficients and the resistor
// through the register port only while idle; the block itself does not enforce it.
module ntc_thermistor_to_celsius #(
   parameter int ADC_BITS       = ntc_pkg::ADC_BITS_DEF,
   parameter int TEMP_FRAC_BITS = ntc_pkg::TEMP_FRAC_DEF
) (
   input logic         clock,
   input logic         reset,
   ntc_req_if.sink     req_bus,
   ntc_rsp_if.source   rsp_bus,
   ntc_csr_if.sink     csr_bus
);
   import ntc_pkg::*;

   localparam int OFF   = ((27315 << TEMP_FRAC_BITS) + 50) / 100;
   localparam int QB    = $clog2(T_MAX_VAL + OFF + 1);
   localparam int T_W   = QB + 2;
   localparam int CMP_W = D_W + QB;
   localparam int TOTAL = LOG_LAT + 4*MUL_LAT + QB + 5;
   localparam int LR_W  = $clog2(RES_W) + FRAC_W;
   localparam int LC_W  = $clog2(ADC_BITS) + FRAC_W;
   localparam logic [ADC_BITS-1:0] FULL = '1;
   localparam logic signed [TEMP_W-1:0] COLD = TEMP_W'(-50 * (2 ** TEMP_FRAC_BITS));

   // configuration registers
   logic [RES_W-1:0]         res_ff;
   logic signed [COEF_W-1:0] coeff_a_ff, coeff_b_ff, coeff_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff     <= RES_RESET;
         coeff_a_ff <= A_RESET;
         coeff_b_ff <= B_RESET;
         coeff_c_ff <= C_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_RES:     res_ff     <= csr_bus.data[RES_W-1:0];
            CSR_COEFF_A: coeff_a_ff <= $signed(csr_bus.data[COEF_W-1:0]);
            CSR_COEFF_B: coeff_b_ff <= $signed(csr_bus.data[COEF_W-1:0]);
            CSR_COEFF_C: coeff_c_ff <= $signed(csr_bus.data[COEF_W-1:0]);
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // pipeline control
   logic [1:0] cnt_ff, cnt_in;
   logic       en, push, pop;
   meta_type   meta_ff [0:TOTAL];
   meta_type   meta_in;

   assign en            = (cnt_ff != 2'd2);
   assign req_bus.ready = en;

   // input stage
   logic [ADC_BITS-1:0] code;
   logic [ADC_BITS-1:0] code_ff, inv_ff;
   logic [RES_W-1:0]    r_ff;

   always_comb begin
      code        = req_bus.adc_code[ADC_BITS-1:0];
      meta_in.vld = req_bus.valid;
      meta_in.oor = (code < ADC_BITS'(LOW_CODE)) || (code > FULL - ADC_BITS'(LOW_CODE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= TOTAL; k++) begin
            meta_ff[k] <= '0;
         end
      end else if (en) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k <= TOTAL; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= code;
         inv_ff  <= FULL - code;
         r_ff    <= (res_ff == '0) ? RES_W'(1) : res_ff;
      end
   end

   // log2 R = log2 r + log2 code - log2 (full - code)
   logic [LR_W-1:0]         lg_r;
   logic [LC_W-1:0]         lg_c, lg_f;
   logic signed [LG_W-1:0]  lg_ff;

   ntc_log2 #(.X_W(RES_W)) u_log_r (
      .clock (clock), .en (en), .x (r_ff), .lg (lg_r)
   );
   ntc_log2 #(.X_W(ADC_BITS)) u_log_c (
      .clock (clock), .en (en), .x (code_ff), .lg (lg_c)
   );
   ntc_log2 #(.X_W(ADC_BITS)) u_log_f (
      .clock (clock), .en (en), .x (inv_ff), .lg (lg_f)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         lg_ff <= $signed(LG_W'(lg_r) + LG_W'(lg_c) - LG_W'(lg_f));
      end
   end

   // polynomial in ln R
   logic signed [PROD_W-1:0] ln, ln2, ln3, bln, cln3;
   logic signed [PROD_W-1:0] ln_dly_ff  [0:MUL_LAT-1];
   logic signed [PROD_W-1:0] bln_dly_ff [0:2*MUL_LAT-1];

   ntc_mulsh u_mul_ln (
      .clock (clock), .en (en), .a (OP_W'(lg_ff)), .b (LN2_Q32), .p (ln)
   );
   ntc_mulsh u_mul_ln2 (
      .clock (clock), .en (en), .a (OP_W'(ln)), .b (OP_W'(ln)), .p (ln2)
   );
   ntc_mulsh u_mul_b (
      .clock (clock), .en (en), .a (OP_W'(coeff_b_ff)), .b (OP_W'(ln)), .p (bln)
   );
   ntc_mulsh u_mul_ln3 (
      .clock (clock), .en (en), .a (OP_W'(ln2)), .b (OP_W'(ln_dly_ff[MUL_LAT-1])),
      .p (ln3)
   );
   ntc_mulsh u_mul_c (
      .clock (clock), .en (en), .a (OP_W'(coeff_c_ff)), .b (OP_W'(ln3)), .p (cln3)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ln_dly_ff[0]  <= ln;
         bln_dly_ff[0] <= bln;
         for (int k = 1; k < MUL_LAT; k++) begin
            ln_dly_ff[k] <= ln_dly_ff[k-1];
         end
         for (int k = 1; k < 2*MUL_LAT; k++) begin
            bln_dly_ff[k] <= bln_dly_ff[k-1];
         end
      end
   end

   // denominator and numerator of the kelvin quotient
   logic signed [D_W-1:0] d_ff;
   logic [D_W-1:0]        rem_ff [0:QB+1];
   logic [D_W-2:0]        dv_ff  [0:QB+1];
   logic [QB:0]           q_ff   [0:QB+1];
   logic                  pos_ff [0:QB+1];

   logic [CMP_W-1:0]      trial [0:QB];
   logic                  ge    [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= D_W'(coeff_a_ff) + D_W'(bln_dly_ff[2*MUL_LAT-1]) + D_W'(cln3);
      end
   end

   // restoring division, one quotient bit per stage; the top bit flags overflow
   always_comb begin
      for (int j = 0; j <= QB; j++) begin
         trial[j] = CMP_W'(dv_ff[j]) << (QB - j);
         ge[j]    = (CMP_W'(rem_ff[j]) >= trial[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (D_W'(1'b1) << (COEF_W + TEMP_FRAC_BITS)) + {1'b0, d_ff[D_W-1:1]};
         dv_ff[0]  <= d_ff[D_W-2:0];
         q_ff[0]   <= '0;
         pos_ff[0] <= !d_ff[D_W-1] && (d_ff != '0);
         for (int j = 0; j <= QB; j++) begin
            rem_ff[j+1] <= ge[j] ? D_W'(CMP_W'(rem_ff[j]) - trial[j]) : rem_ff[j];
            dv_ff[j+1]  <= dv_ff[j];
            q_ff[j+1]   <= q_ff[j] | ((QB+1)'(ge[j]) << (QB - j));
            pos_ff[j+1] <= pos_ff[j];
         end
      end
   end

   // kelvin to celsius, range checks
   logic [QB:0]           q_top;
   logic signed [T_W-1:0] t_full;
   result_type            rslt_in, rslt_ff;

   always_comb begin
      q_top  = q_ff[QB+1];
      t_full = $signed({2'b00, q_top[QB-1:0]}) - T_W'(OFF);
      priority if (meta_ff[TOTAL-1].oor) begin
         rslt_in.temperature = COLD;
         rslt_in.status      = STAT_RANGE;
      end else if (!pos_ff[QB+1] || q_top[QB]) begin
         rslt_in.temperature = T_MAX;
         rslt_in.status      = STAT_SAT;
      end else if (t_full > T_W'(T_MAX)) begin
         rslt_in.temperature = T_MAX;
         rslt_in.status      = STAT_SAT;
      end else if (t_full < T_W'(T_MIN)) begin
         rslt_in.temperature = T_MIN;
         rslt_in.status      = STAT_SAT;
      end else begin
         rslt_in.temperature = TEMP_W'(t_full);
         rslt_in.status      = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rslt_ff <= rslt_in;
      end
   end

   // two-entry output buffer
   result_type hd_ff, tl_ff;

   always_comb begin
      push   = en && meta_ff[TOTAL].vld;
      pop    = rsp_bus.valid && rsp_bus.ready;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            hd_ff <= tl_ff;
         end else if (push) begin
            hd_ff <= rslt_ff;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            hd_ff <= rslt_ff;
         end else begin
            tl_ff <= rslt_ff;
         end
      end
   end

   assign rsp_bus.valid       = (cnt_ff != 2'd0);
   assign rsp_bus.temperature = hd_ff.temperature;
   assign rsp_bus.status      = hd_ff.status;

   a_range_cold : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STAT_RANGE |-> rsp_bus.temperature == COLD)
      else $error("out-of-range code without the cold value");

   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STAT_SAT
      |-> rsp_bus.temperature == T_MAX || rsp_bus.temperature == T_MIN)
      else $error("saturated status without a bound value");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.status == STAT_OK || rsp_bus.status == STAT_RANGE
                        || rsp_bus.status == STAT_SAT)
      else $error("undefined status on a transaction");

endmodule

### rtl/ntc_log2.sv
// pipelined log2 in Q32: normalize stage, then one squaring step per stage
`timescale 1ns / 1ps
module ntc_log2 #(
   parameter int X_W = ntc_pkg::RES_W
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [X_W-1:0]                            x,
   output logic [$clog2(X_W)+ntc_pkg::FRAC_W-1:0]    lg
);
   import ntc_pkg::*;

   localparam int N_W = $clog2(X_W);

   logic [N_W-1:0]    n_ff [0:FRAC_W];
   logic [NORM_W-1:0] y_ff [0:FRAC_W];
   logic [FRAC_W-1:0] f_ff [0:FRAC_W];

   logic [N_W-1:0]    n_in;
   logic [NORM_W-1:0] y_in;
   logic [NORM_W:0]   y2 [0:FRAC_W-1];

   // leading one and mantissa in [2^30, 2^31)
   always_comb begin
      n_in = '0;
      for (int i = 1; i < X_W; i++) begin
         if (x[i]) begin
            n_in = N_W'(i);
         end
      end
      y_in = {{(NORM_W-X_W){1'b0}}, x} << (5'(NORM_W-1) - 5'(n_in));
   end

   always_comb begin
      logic [2*NORM_W-1:0] sq;
      for (int k = 0; k < FRAC_W; k++) begin
         sq    = y_ff[k] * y_ff[k];
         y2[k] = sq[2*NORM_W-1 -: NORM_W+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= n_in;
         y_ff[0] <= y_in;
         f_ff[0] <= '0;
         for (int k = 0; k < FRAC_W; k++) begin
            n_ff[k+1] <= n_ff[k];
            y_ff[k+1] <= y2[k][NORM_W] ? y2[k][NORM_W:1] : y2[k][NORM_W-1:0];
            f_ff[k+1] <= {f_ff[k][FRAC_W-2:0], y2[k][NORM_W]};
         end
      end
   end

   assign lg = {n_ff[FRAC_W], f_ff[FRAC_W]};

endmodule

### rtl/ntc_mulsh.sv
// four-stage signed multiply, round half away from zero, shift by 32, saturate
`timescale 1ns / 1ps
module ntc_mulsh (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [ntc_pkg::OP_W-1:0]    a,
   input  logic signed [ntc_pkg::OP_W-1:0]    b,
   output logic signed [ntc_pkg::PROD_W-1:0]  p
);
   import ntc_pkg::*;

   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [MAG_W-1:0]         ma_ff, mb_ff;
   logic [2*HALF_W-1:0]      p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*MAG_W-1:0]       full_ff;
   logic signed [PROD_W-1:0] p_ff;

   logic signed [OP_W-1:0]   na, nb;
   logic [MAG_W-1:0]         ma_in, mb_in;
   logic [2*HALF_W-1:0]      p00_in, p01_in, p10_in, p11_in;
   logic [2*MAG_W-1:0]       full_in;
   logic [2*MAG_W:0]         rnd;
   logic [2*MAG_W-PROD_SHIFT:0] sh;
   logic [PROD_W-2:0]        mag;
   logic signed [PROD_W-1:0] p_in;

   always_comb begin
      na      = -a;
      nb      = -b;
      ma_in   = a[OP_W-1] ? na[MAG_W-1:0] : a[MAG_W-1:0];
      mb_in   = b[OP_W-1] ? nb[MAG_W-1:0] : b[MAG_W-1:0];
      p00_in  = ma_ff[HALF_W-1:0] * mb_ff[HALF_W-1:0];
      p01_in  = ma_ff[HALF_W-1:0] * mb_ff[MAG_W-1:HALF_W];
      p10_in  = ma_ff[MAG_W-1:HALF_W] * mb_ff[HALF_W-1:0];
      p11_in  = ma_ff[MAG_W-1:HALF_W] * mb_ff[MAG_W-1:HALF_W];
      full_in = {p11_ff, p00_ff}
              + {{HALF_W{1'b0}}, p01_ff, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, p10_ff, {HALF_W{1'b0}}};
      rnd     = {1'b0, full_ff} + ((2*MAG_W+1)'(1) << (PROD_SHIFT-1));
      sh      = rnd[2*MAG_W:PROD_SHIFT];
      mag     = (sh > (2*MAG_W-PROD_SHIFT+1)'(PROD_LIM)) ? PROD_LIM : sh[PROD_W-2:0];
      p_in    = neg3_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a[OP_W-1] ^ b[OP_W-1];
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg2_ff <= neg1_ff;
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg3_ff <= neg2_ff;
         full_ff <= full_in;
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

### tb/tb.sv
// testbench for the thermistor code to celsius conversion block
`timescale 1ns / 1ps
module tb;
   import ntc_pkg::*;

   localparam int FULL_CODE = 4095;
   localparam int LATENCY   = 75;
   localparam int PAUSE     = LATENCY + 10;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint TEMP_OFFSET = ((longint'(27315) << TEMP_FRAC_DEF) + 50) / 100;
   localparam longint LN2_FIX = 64'd2977044472;

   typedef struct {
      logic [11:0] code;
      bit          typed;
      int          temp;
      status_type  stat;
   } stim_row_t;

   typedef struct {
      logic [RES_W-1:0]          res;
      logic signed [COEF_W-1:0]  a;
      logic signed [COEF_W-1:0]  b;
      logic signed [COEF_W-1:0]  c;
   } coeff_set_t;

   logic clock = 0;
   logic reset = 1;

   ntc_req_if req_bus ();
   ntc_rsp_if rsp_bus ();
   ntc_csr_if csr_bus ();

   ntc_thermistor_to_celsius dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   coeff_set_t cur;
   result_type temps_due[$];
   int   errors = 0;
   bit   quiet = 0;
   bit   hold_off = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // round(a*b / 2^32) with the magnitude clamped
   function automatic longint mul_round32(longint a, longint b);
      bit          neg;
      bit [63:0]   ua, ub;
      bit [127:0]  p;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 64'd0 - a : a;
      ub = b < 0 ? 64'd0 - b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = (p + 128'h8000_0000) >> 32;
      if (p > (128'd1 << 61))
         p = 128'd1 << 61;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   // log2 with 32 fraction bits, truncated
   function automatic longint log2_fix(bit [63:0] x);
      int         n;
      bit [63:0]  y, frac;
      n = 0;
      frac = 0;
      while (n < 63 && (x >> (n + 1)) != 0)
         n++;
      y = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
      for (int i = 0; i < 32; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return longint'((64'(n) << 32) | frac);
   endfunction

   function automatic result_type celsius_of(logic [11:0] code);
      result_type r;
      longint     lg, ln, ln3, d, t;
      bit [63:0]  q, ohms;
      r.status = STAT_OK;
      if (code < LOW_CODE || code > FULL_CODE - LOW_CODE) begin
         t = -50 * 256;
         r.status = STAT_RANGE;
      end else begin
         ohms = cur.res == 0 ? 64'd1 : 64'(cur.res);
         lg = log2_fix(ohms) + log2_fix(64'(code)) - log2_fix(64'(FULL_CODE - code));
         ln = mul_round32(lg, LN2_FIX);
         ln3 = mul_round32(mul_round32(ln, ln), ln);
         d = longint'(cur.a) + mul_round32(longint'(cur.b), ln)
             + mul_round32(longint'(cur.c), ln3);
         if (d <= 0) begin
            t = T_MAX_VAL;
            r.status = STAT_SAT;
         end else begin
            q = ((64'd1 << 56) + (64'(d) >> 1)) / 64'(d);
            t = longint'(q) - TEMP_OFFSET;
            if (t > T_MAX_VAL) begin
               t = T_MAX_VAL;
               r.status = STAT_SAT;
            end else if (t < -524288) begin
               t = -524288;
               r.status = STAT_SAT;
            end
         end
      end
      r.temperature = t[TEMP_W-1:0];
      return r;
   endfunction

   task automatic send_code(logic [11:0] code, bit typed = 0, int temp = 0,
                            status_type stat = STAT_OK);
      result_type r;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.adc_code <= code;
      do @(posedge clock); while (!req_bus.ready);
      if (typed) begin
         r.temperature = temp[TEMP_W-1:0];
         r.status = stat;
      end else
         r = celsius_of(code);
      temps_due.push_back(r);
   endtask

   task automatic maybe_gap();
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 3);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (temps_due.size() == 0);
      repeat (PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_RES:     cur.res = val[RES_W-1:0];
         CSR_COEFF_A: cur.a = val[COEF_W-1:0];
         CSR_COEFF_B: cur.b = val[COEF_W-1:0];
         CSR_COEFF_C: cur.c = val[COEF_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_set(coeff_set_t s);
      write_reg(CSR_RES, 48'(s.res));
      write_reg(CSR_COEFF_A, s.a);
      write_reg(CSR_COEFF_B, s.b);
      write_reg(CSR_COEFF_C, s.c);
   endtask

   function automatic logic [11:0] pick_code();
      if ($urandom_range(0, 9) == 0)
         return 12'($urandom_range(0, FULL_CODE));
      return 12'($urandom_range(LOW_CODE, FULL_CODE - LOW_CODE));
   endfunction

   function automatic logic signed [COEF_W-1:0] nudge(logic signed [COEF_W-1:0] v);
      longint k;
      k = longint'($urandom_range(0, 400)) - 200;
      return COEF_W'(longint'(v) + (longint'(v) / 1000) * k);
   endfunction

   // transaction checker on the result side
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (temps_due.size() == 0) begin
            $display("%0t: unexpected result temp %0d status %0d", $time,
                     rsp_bus.temperature, rsp_bus.status);
            errors++;
         end else begin
            want = temps_due.pop_front();
            if (rsp_bus.temperature !== want.temperature) begin
               $display("%0t: temperature expected %0d actual %0d", $time,
                        want.temperature, rsp_bus.temperature);
               errors++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_bus.status);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clock);
         end else
            rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_t  rows[$];
      coeff_set_t sets[$];
      coeff_set_t s;
      req_bus.valid = 1'b0;
      req_bus.adc_code = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_RES;
      csr_bus.data = '0;
      cur = '{RES_RESET, A_RESET, B_RESET, C_RESET};

      rows = '{
         '{12'd0,    1, -12800, STAT_RANGE},
         '{12'd9,    1, -12800, STAT_RANGE},
         '{12'd4086, 1, -12800, STAT_RANGE},
         '{12'd4095, 1, -12800, STAT_RANGE},
         '{12'd1,    1, -12800, STAT_RANGE},
         '{12'd10,   0, 0, STAT_OK},
         '{12'd4085, 0, 0, STAT_OK},
         '{12'd2048, 0, 0, STAT_OK},
         '{12'd2047, 0, 0, STAT_OK},
         '{12'd1365, 0, 0, STAT_OK},
         '{12'd2730, 0, 0, STAT_OK},
         '{12'd11,   0, 0, STAT_OK},
         '{12'd4084, 0, 0, STAT_OK},
         '{12'd3000, 0, 0, STAT_OK}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         send_code(rows[i].code, rows[i].typed, rows[i].temp, rows[i].stat);
         maybe_gap();
      end
      drain();

      // extremes first, then perturbed settings near the defaults, and the defaults last
      sets.push_back('{24'd0, A_RESET, B_RESET, C_RESET});
      sets.push_back('{24'hFFFFFF, A_RESET, B_RESET, C_RESET});
      sets.push_back('{24'd1, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
                       48'sh7FFF_FFFF_FFFF});
      sets.push_back('{24'd5000, 48'sh8000_0000_0000, 48'sh8000_0000_0000,
                       48'sh8000_0000_0000});
      sets.push_back('{24'd10000, 48'sd1, 48'sd0, 48'sd0});
      repeat (3) begin
         s.res = 24'($urandom_range(1000, 200000));
         s.a = nudge(A_RESET);
         s.b = nudge(B_RESET);
         s.c = nudge(C_RESET);
         sets.push_back(s);
      end
      sets.push_back('{RES_RESET, A_RESET, B_RESET, C_RESET});

      foreach (sets[p]) begin
         load_set(sets[p]);
         if (p == sets.size() - 1)
            quiet = 1;
         for (int k = 0; k < 75; k++) begin
            // block fills behind a long receiver stall
            if (p == 5 && k == 10)
               hold_off = 1;
            send_code(pick_code());
            maybe_gap();
         end
         drain();
      end

      if (errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end
endmodule

### files.f
rtl/ntc_pkg.sv
rtl/ntc_if.sv
rtl/ntc_log2.sv
rtl/ntc_mulsh.sv
rtl/ntc_thermistor_to_celsius.sv
tb/tb.sv
